>>> rtl/lfs_pkg.sv
package lfs_pkg;

  // Configuration register map, one 32-bit word per register.
  typedef enum logic [1:0] {
    REG_LORENTZ = 2'd0,
    REG_SPIN    = 2'd1,
    REG_LONG    = 2'd2,
    REG_TRANS   = 2'd3
  } reg_idx_t;

  localparam int ADDR_W = 4;

  // Square root: 32 result bits, resolved a fixed number of bits per stage.
  localparam int SQ_STEPS  = 32;
  localparam int SQ_SPS    = 2;
  localparam int SQ_STAGES = SQ_STEPS / SQ_SPS;

  // Normalizing divide: (|p_i| << 16) / |p|, quotient at most 2^16.
  localparam int DIV_FRAC   = 16;
  localparam int DIV_STEPS  = 18;
  localparam int DIV_SPS    = 2;
  localparam int DIV_STAGES = DIV_STEPS / DIV_SPS;

  // Multiply, shift and saturate unit latency.
  localparam int MUL_LAT = 4;

  typedef struct packed {
    logic signed [31:0] mom_x;
    logic signed [31:0] mom_y;
    logic signed [31:0] mom_z;
    logic signed [31:0] spin_x;
    logic signed [31:0] spin_y;
    logic signed [31:0] spin_z;
    logic signed [31:0] field_x;
    logic signed [31:0] field_y;
    logic signed [31:0] field_z;
  } lfs_in_t;

  typedef struct packed {
    logic signed [31:0] dir_x;
    logic signed [31:0] dir_y;
    logic signed [31:0] dir_z;
    logic signed [31:0] dmom_x;
    logic signed [31:0] dmom_y;
    logic signed [31:0] dmom_z;
    logic signed [31:0] dspin_x;
    logic signed [31:0] dspin_y;
    logic signed [31:0] dspin_z;
    logic               zero_momentum;
  } lfs_out_t;

endpackage

>>> rtl/lfs_delay.sv
module lfs_delay #(
  parameter int W = 1,
  parameter int N = 1
) (
  input  logic         clk,
  input  logic         en,
  input  logic [W-1:0] d,
  output logic [W-1:0] q
);

  logic [W-1:0] tap [N];

  always_ff @(posedge clk) begin
    if (en) begin
      tap[0] <= d;
      for (int i = 1; i < N; i++) begin
        tap[i] <= tap[i-1];
      end
    end
  end

  assign q = tap[N-1];

endmodule

>>> rtl/lfs_isqrt.sv
module lfs_isqrt (
  input  logic        clk,
  input  logic        en,
  input  logic [63:0] n,
  output logic [31:0] root
);

  localparam int NS  = lfs_pkg::SQ_STAGES;
  localparam int SPS = lfs_pkg::SQ_SPS;

  logic [34:0] rem_q [NS];
  logic [31:0] rt_q  [NS];
  logic [63:0] nb_q  [NS];

  for (genvar g = 0; g < NS; g++) begin : g_st
    logic [34:0] rem_i;
    logic [31:0] rt_i;
    logic [63:0] nb_i;
    logic [34:0] rem_c;
    logic [31:0] rt_c;
    logic [63:0] nb_c;
    logic [34:0] r2;
    logic [34:0] trial;

    if (g == 0) begin : g_first
      assign rem_i = '0;
      assign rt_i  = '0;
      assign nb_i  = n;
    end else begin : g_next
      assign rem_i = rem_q[g-1];
      assign rt_i  = rt_q[g-1];
      assign nb_i  = nb_q[g-1];
    end

    // Restoring square root, two radicand bits per step.
    always_comb begin
      rem_c = rem_i;
      rt_c  = rt_i;
      nb_c  = nb_i;
      r2    = '0;
      trial = '0;
      for (int k = 0; k < SPS; k++) begin
        r2    = {rem_c[32:0], nb_c[63:62]};
        trial = {1'b0, rt_c, 2'b01};
        if (r2 >= trial) begin
          rem_c = r2 - trial;
          rt_c  = {rt_c[30:0], 1'b1};
        end else begin
          rem_c = r2;
          rt_c  = {rt_c[30:0], 1'b0};
        end
        nb_c = {nb_c[61:0], 2'b00};
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_q[g] <= rem_c;
        rt_q[g]  <= rt_c;
        nb_q[g]  <= nb_c;
      end
    end
  end

  assign root = rt_q[NS-1];

endmodule

>>> rtl/lfs_div.sv
module lfs_div (
  input  logic        clk,
  input  logic        en,
  input  logic [31:0] num,
  input  logic [31:0] den,
  output logic [16:0] quot
);

  localparam int NS    = lfs_pkg::DIV_STAGES;
  localparam int SPS   = lfs_pkg::DIV_SPS;
  localparam int STEPS = lfs_pkg::DIV_STEPS;
  localparam int NW    = 32 + lfs_pkg::DIV_FRAC;

  logic [32:0]      r_q   [NS];
  logic [STEPS-1:0] nb_q  [NS];
  logic [STEPS-1:0] q_q   [NS];
  logic [31:0]      den_q [NS];

  logic [NW-1:0] numw;
  assign numw = {num, {lfs_pkg::DIV_FRAC{1'b0}}};

  for (genvar g = 0; g < NS; g++) begin : g_st
    logic [32:0]      r_i;
    logic [STEPS-1:0] nb_i;
    logic [STEPS-1:0] q_i;
    logic [31:0]      den_i;
    logic [32:0]      r_c;
    logic [STEPS-1:0] nb_c;
    logic [STEPS-1:0] q_c;
    logic [32:0]      r2;

    if (g == 0) begin : g_first
      // The top bits are already below the divisor since |p_i| <= |p|.
      assign r_i   = 33'(numw[NW-1:STEPS]);
      assign nb_i  = numw[STEPS-1:0];
      assign q_i   = '0;
      assign den_i = den;
    end else begin : g_next
      assign r_i   = r_q[g-1];
      assign nb_i  = nb_q[g-1];
      assign q_i   = q_q[g-1];
      assign den_i = den_q[g-1];
    end

    always_comb begin
      r_c  = r_i;
      nb_c = nb_i;
      q_c  = q_i;
      r2   = '0;
      for (int k = 0; k < SPS; k++) begin
        r2 = {r_c[31:0], nb_c[STEPS-1]};
        if (r2 >= {1'b0, den_i}) begin
          r_c = r2 - {1'b0, den_i};
          q_c = {q_c[STEPS-2:0], 1'b1};
        end else begin
          r_c = r2;
          q_c = {q_c[STEPS-2:0], 1'b0};
        end
        nb_c = {nb_c[STEPS-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        r_q[g]   <= r_c;
        nb_q[g]  <= nb_c;
        q_q[g]   <= q_c;
        den_q[g] <= den_i;
      end
    end
  end

  assign quot = q_q[NS-1][16:0];

endmodule

>>> rtl/lfs_mulsat.sv
module lfs_mulsat #(
  parameter int AW    = 52,
  parameter int SHIFT = 40
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic signed [AW-1:0] a,
  input  logic signed [31:0]   b,
  output logic signed [31:0]   y
);

  localparam int HW = AW - 32;
  localparam int PW = AW + 32;
  localparam int RW = PW - SHIFT;
  localparam logic [RW-1:0] POS_LIM = RW'(64'h7fff_ffff);
  localparam logic [RW-1:0] NEG_LIM = RW'(64'h8000_0000);

  logic [AW-1:0]    amag;
  logic [31:0]      bmag;
  logic             neg1;
  logic             neg2;
  logic             neg3;
  logic [63:0]      lo;
  logic [HW+31:0]   hi;
  logic [PW-1:0]    full;
  logic [RW-1:0]    mag3;

  // The magnitude is split in two registered partial products, which are then summed and registered.
  assign full = {hi, 32'b0} + PW'(lo);

  always_ff @(posedge clk) begin
    if (en) begin
      amag <= a[AW-1] ? -a : a;
      bmag <= b[31] ? -b : b;
      neg1 <= a[AW-1] ^ b[31];

      lo   <= 64'(amag[31:0]) * 64'(bmag);
      hi   <= (HW+32)'(amag[AW-1:32]) * (HW+32)'(bmag);
      neg2 <= neg1;

      mag3 <= full[PW-1:SHIFT];
      neg3 <= neg2;

      if (neg3) begin
        y <= (mag3 > NEG_LIM) ? 32'h8000_0000 : -mag3[31:0];
      end else begin
        y <= (mag3 > POS_LIM) ? 32'h7fff_ffff : mag3[31:0];
      end
    end
  end

endmodule

>>> rtl/lorentz_force_spin_precession_rhs_core.sv
// Spin precession right-hand side: each request carries momentum, spin and
// field vectors and yields the unit direction, the saturated momentum
// derivative and the saturated spin derivative, all signed Q16.16, plus a
// zero-momentum flag. The pipeline takes one request per cycle unless the
// output stalls; its depth is set by the 16-stage square root of |p|^2, the
// 9-stage normalizing divider and three chained 4-stage multiply-shift-
// saturate units on the spin path. A stall at the output holds the whole
// pipeline in place. The four Q8.24 coefficients sit at byte addresses 0, 4,
// 8 and 12 and should only be written while no request is in flight.
module lorentz_force_spin_precession_rhs_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  lfs_pkg::lfs_in_t              in_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output lfs_pkg::lfs_out_t             out_data,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [lfs_pkg::ADDR_W-1:0]    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);

  localparam int ML     = lfs_pkg::MUL_LAT;
  localparam int S_ROOT = 2 + lfs_pkg::SQ_STAGES;
  localparam int S_Q    = S_ROOT + lfs_pkg::DIV_STAGES;
  localparam int S_U    = S_Q + 1;
  localparam int S_OP   = S_U + 2;
  localparam int S_M1   = S_OP + ML;
  localparam int S_M2   = S_M1 + ML;
  localparam int S_DIFF = S_M2 + 1;
  localparam int S_M3   = S_DIFF + ML;
  localparam int LAT    = S_M3 + 1;

  // ---------------------------------------------------------------- config
  logic signed [31:0] lorentz_coef;
  logic signed [31:0] spin_coef;
  logic signed [31:0] long_coef;
  logic signed [31:0] trans_coef;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      lorentz_coef <= '0;
      spin_coef    <= '0;
      long_coef    <= '0;
      trans_coef   <= '0;
    end else if (psel && penable && pwrite) begin
      case (lfs_pkg::reg_idx_t'(paddr[3:2]))
        lfs_pkg::REG_LORENTZ: lorentz_coef <= pwdata;
        lfs_pkg::REG_SPIN:    spin_coef    <= pwdata;
        lfs_pkg::REG_LONG:    long_coef    <= pwdata;
        lfs_pkg::REG_TRANS:   trans_coef   <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (lfs_pkg::reg_idx_t'(paddr[3:2]))
      lfs_pkg::REG_LORENTZ: prdata = lorentz_coef;
      lfs_pkg::REG_SPIN:    prdata = spin_coef;
      lfs_pkg::REG_LONG:    prdata = long_coef;
      lfs_pkg::REG_TRANS:   prdata = trans_coef;
      default:              prdata = '0;
    endcase
  end

  // ------------------------------------------------------------- flow control
  logic           adv;
  logic [LAT-1:0] vld;

  assign out_valid = vld[LAT-1];
  assign adv       = !(out_valid && out_stall);
  assign in_stall  = !adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[LAT-2:0], in_valid};
    end
  end

  // ---------------------------------------------------- stage 1: squares
  logic signed [31:0] p_in [3];
  logic signed [31:0] s_in [3];
  logic signed [31:0] b_in [3];
  logic signed [63:0] pw   [3];

  assign p_in[0] = in_data.mom_x;
  assign p_in[1] = in_data.mom_y;
  assign p_in[2] = in_data.mom_z;
  assign s_in[0] = in_data.spin_x;
  assign s_in[1] = in_data.spin_y;
  assign s_in[2] = in_data.spin_z;
  assign b_in[0] = in_data.field_x;
  assign b_in[1] = in_data.field_y;
  assign b_in[2] = in_data.field_z;

  logic [62:0]        sq1 [3];
  logic signed [31:0] p1  [3];
  logic signed [31:0] s1  [3];
  logic signed [31:0] b1  [3];
  logic               zero1;

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        sq1[i] <= 63'(pw[i] * pw[i]);
        p1[i]  <= p_in[i];
        s1[i]  <= s_in[i];
        b1[i]  <= b_in[i];
      end
      zero1 <= (p_in[0] == '0) && (p_in[1] == '0) && (p_in[2] == '0);
    end
  end

  for (genvar i = 0; i < 3; i++) begin : g_pw
    assign pw[i] = 64'(p_in[i]);
  end

  // ------------------------------------- stage 2: sum of squares, magnitudes
  logic [63:0]        sq2;
  logic [31:0]        pmag2 [3];
  logic [31:0]        smag2 [3];
  logic [31:0]        bmag2 [3];
  logic signed [31:0] s2    [3];
  logic signed [31:0] b2    [3];
  logic [2:0]         psgn2;

  always_ff @(posedge clk) begin
    if (adv) begin
      sq2 <= 64'(sq1[0]) + 64'(sq1[1]) + 64'(sq1[2]);
      for (int i = 0; i < 3; i++) begin
        pmag2[i] <= p1[i][31] ? -p1[i] : p1[i];
        smag2[i] <= s1[i][31] ? -s1[i] : s1[i];
        bmag2[i] <= b1[i][31] ? -b1[i] : b1[i];
        s2[i]    <= s1[i];
        b2[i]    <= b1[i];
        psgn2[i] <= p1[i][31];
      end
    end
  end

  // ------------------------------------------ |p| and unit direction
  logic [31:0] root;
  logic [31:0] pmag_r [3];
  logic [16:0] q27    [3];
  logic [2:0]  psgn27;

  lfs_isqrt u_isqrt (
    .clk  (clk),
    .en   (adv),
    .n    (sq2),
    .root (root)
  );

  lfs_delay #(.W(3), .N(S_Q - 2)) u_dly_psgn (
    .clk (clk), .en (adv), .d (psgn2), .q (psgn27)
  );

  logic signed [31:0] s28    [3];
  logic signed [31:0] b28    [3];
  logic [31:0]        smag28 [3];
  logic [31:0]        bmag28 [3];
  logic signed [17:0] u28    [3];

  for (genvar i = 0; i < 3; i++) begin : g_lane
    lfs_delay #(.W(32), .N(S_ROOT - 2)) u_dly_pmag (
      .clk (clk), .en (adv), .d (pmag2[i]), .q (pmag_r[i])
    );

    lfs_div u_div (
      .clk  (clk),
      .en   (adv),
      .num  (pmag_r[i]),
      .den  (root),
      .quot (q27[i])
    );

    lfs_delay #(.W(128), .N(S_U - 2)) u_dly_sb (
      .clk (clk),
      .en  (adv),
      .d   ({s2[i], b2[i], smag2[i], bmag2[i]}),
      .q   ({s28[i], b28[i], smag28[i], bmag28[i]})
    );

    always_ff @(posedge clk) begin
      if (adv) begin
        u28[i] <= psgn27[i] ? -{1'b0, q27[i]} : {1'b0, q27[i]};
      end
    end
  end

  // ----------------------------------- stages after u: products, then sums
  logic signed [49:0] pub_a [3];
  logic signed [49:0] pub_b [3];
  logic [47:0]        psb_a [3];
  logic [47:0]        psb_b [3];
  logic               nsb_a [3];
  logic               nsb_b [3];
  logic signed [49:0] psu_a [3];
  logic signed [49:0] psu_b [3];
  logic signed [49:0] pbu   [3];
  logic [63:0]        sbp_a [3];
  logic [63:0]        sbp_b [3];
  logic signed [49:0] sva   [3];
  logic signed [49:0] svb   [3];

  logic signed [50:0] ub30  [3];
  logic signed [49:0] sb30  [3];
  logic signed [50:0] su30  [3];
  logic signed [51:0] bdu30;

  for (genvar i = 0; i < 3; i++) begin : g_cross
    localparam int J = (i + 1) % 3;
    localparam int K = (i + 2) % 3;

    assign sbp_a[i] = 64'(smag28[J]) * 64'(bmag28[K]);
    assign sbp_b[i] = 64'(smag28[K]) * 64'(bmag28[J]);

    // Spin-cross-field terms truncate toward zero before the difference.
    assign sva[i] = nsb_a[i] ? -{2'b00, psb_a[i]} : {2'b00, psb_a[i]};
    assign svb[i] = nsb_b[i] ? -{2'b00, psb_b[i]} : {2'b00, psb_b[i]};

    always_ff @(posedge clk) begin
      if (adv) begin
        pub_a[i] <= 50'(u28[J]) * 50'(b28[K]);
        pub_b[i] <= 50'(u28[K]) * 50'(b28[J]);
        psb_a[i] <= sbp_a[i][63:16];
        psb_b[i] <= sbp_b[i][63:16];
        nsb_a[i] <= s28[J][31] ^ b28[K][31];
        nsb_b[i] <= s28[K][31] ^ b28[J][31];
        psu_a[i] <= 50'(s28[J]) * 50'(u28[K]);
        psu_b[i] <= 50'(s28[K]) * 50'(u28[J]);
        pbu[i]   <= 50'(b28[i]) * 50'(u28[i]);

        ub30[i] <= 51'(pub_a[i]) - 51'(pub_b[i]);
        sb30[i] <= sva[i] - svb[i];
        su30[i] <= 51'(psu_a[i]) - 51'(psu_b[i]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      bdu30 <= 52'(pbu[0]) + 52'(pbu[1]) + 52'(pbu[2]);
    end
  end

  // --------------------------------------------- scaled and saturated terms
  logic signed [31:0] udb34;
  logic signed [31:0] dmom34  [3];
  logic signed [31:0] tp34    [3];
  logic signed [31:0] tp38    [3];
  logic signed [50:0] su34    [3];
  logic signed [31:0] lp38    [3];
  logic signed [32:0] diff39  [3];
  logic signed [31:0] dspin43 [3];
  logic signed [31:0] dmom43  [3];
  logic signed [17:0] u43     [3];
  logic               zero43;

  lfs_mulsat #(.AW(52), .SHIFT(40)) u_udb (
    .clk (clk), .en (adv), .a (bdu30), .b (long_coef), .y (udb34)
  );

  for (genvar i = 0; i < 3; i++) begin : g_scale
    lfs_mulsat #(.AW(51), .SHIFT(40)) u_dmom (
      .clk (clk), .en (adv), .a (ub30[i]), .b (lorentz_coef), .y (dmom34[i])
    );

    lfs_mulsat #(.AW(50), .SHIFT(24)) u_tp (
      .clk (clk), .en (adv), .a (sb30[i]), .b (trans_coef), .y (tp34[i])
    );

    lfs_delay #(.W(51), .N(ML)) u_dly_su (
      .clk (clk), .en (adv), .d (su30[i]), .q (su34[i])
    );

    lfs_mulsat #(.AW(51), .SHIFT(32)) u_lp (
      .clk (clk), .en (adv), .a (su34[i]), .b (udb34), .y (lp38[i])
    );

    lfs_delay #(.W(32), .N(ML)) u_dly_tp (
      .clk (clk), .en (adv), .d (tp34[i]), .q (tp38[i])
    );

    always_ff @(posedge clk) begin
      if (adv) begin
        diff39[i] <= 33'(tp38[i]) - 33'(lp38[i]);
      end
    end

    lfs_mulsat #(.AW(33), .SHIFT(24)) u_dspin (
      .clk (clk), .en (adv), .a (diff39[i]), .b (spin_coef), .y (dspin43[i])
    );

    lfs_delay #(.W(32), .N(S_M3 - S_M1)) u_dly_dmom (
      .clk (clk), .en (adv), .d (dmom34[i]), .q (dmom43[i])
    );

    lfs_delay #(.W(18), .N(S_M3 - S_U)) u_dly_u (
      .clk (clk), .en (adv), .d (u28[i]), .q (u43[i])
    );
  end

  lfs_delay #(.W(1), .N(S_M3 - 1)) u_dly_zero (
    .clk (clk), .en (adv), .d (zero1), .q (zero43)
  );

  // ------------------------------------------------------- output register
  lfs_pkg::lfs_out_t out_next;

  always_comb begin
    out_next = '0;
    out_next.zero_momentum = zero43;
    if (!zero43) begin
      out_next.dir_x   = 32'(u43[0]);
      out_next.dir_y   = 32'(u43[1]);
      out_next.dir_z   = 32'(u43[2]);
      out_next.dmom_x  = dmom43[0];
      out_next.dmom_y  = dmom43[1];
      out_next.dmom_z  = dmom43[2];
      out_next.dspin_x = dspin43[0];
      out_next.dspin_y = dspin43[1];
      out_next.dspin_z = dspin43[2];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data <= out_next;
    end
  end

`ifndef NO_ASSERTIONS
  // A held result freezes every stage, valid bits included.
  a_stall_freezes: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(vld))
    else $error("pipeline moved while the output was stalled");

  a_zero_clears: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.zero_momentum |->
      out_data.dir_x == 0 && out_data.dir_y == 0 && out_data.dir_z == 0 &&
      out_data.dmom_x == 0 && out_data.dmom_y == 0 && out_data.dmom_z == 0 &&
      out_data.dspin_x == 0 && out_data.dspin_y == 0 && out_data.dspin_z == 0)
    else $error("zero momentum result carries nonzero fields");

  // Each direction component is a quotient of |p_i| by |p| and stays within one.
  a_unit_dir: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.zero_momentum |->
      out_data.dir_x <= 32'sd65536 && out_data.dir_x >= -32'sd65536 &&
      out_data.dir_y <= 32'sd65536 && out_data.dir_y >= -32'sd65536 &&
      out_data.dir_z <= 32'sd65536 && out_data.dir_z >= -32'sd65536)
    else $error("direction component exceeds unit magnitude");
`endif

endmodule

>>> bench/tb_lorentz_force_spin_precession_rhs_core.sv
module tb_lorentz_force_spin_precession_rhs_core;
  timeunit 1ns;
  timeprecision 1ps;
  import lfs_pkg::*;

  localparam int LATENCY = 44;
  localparam int CYCLE_LIMIT = 400000;

  logic clk;
  logic rst;
  logic in_valid;
  logic in_stall;
  lfs_in_t in_data;
  logic out_valid;
  logic out_stall;
  lfs_out_t out_data;
  logic psel, penable, pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic pready;

  lorentz_force_spin_precession_rhs_core dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // Coefficients as the predictor sees them.
  logic signed [31:0] k_lorentz, k_spin, k_long, k_trans;

  lfs_in_t request_queue[$];
  lfs_out_t expected_rhs[$];
  int errors;
  int cycles;
  bit quiet;
  int send_gap, recv_gap;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic logic [63:0] mag(input logic signed [63:0] a);
    return a < 0 ? -a : a;
  endfunction

  function automatic logic [63:0] int_sqrt(input logic [63:0] n);
    logic [63:0] res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n = n - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  // Product shifted right toward zero, clamped to signed 32 bits.
  function automatic logic signed [31:0] scale_sat(input logic signed [63:0] a,
                                                   input logic signed [63:0] b,
                                                   input int sh);
    logic [127:0] prod;
    logic [127:0] r;
    bit neg;
    prod = 128'(mag(a)) * 128'(mag(b));
    r = prod >> sh;
    neg = (a < 0) != (b < 0);
    if (neg) begin
      if (r > 128'h8000_0000) return 32'sh8000_0000;
      return 32'(-$signed(r[63:0]));
    end
    if (r > 128'h7fff_ffff) return 32'sh7fff_ffff;
    return 32'(r[31:0]);
  endfunction

  function automatic logic signed [63:0] prod_q16(input logic signed [63:0] a,
                                                  input logic signed [63:0] b);
    logic [63:0] q;
    q = (mag(a) * mag(b)) >> 16;
    return ((a < 0) != (b < 0)) ? -$signed(q) : $signed(q);
  endfunction

  function automatic lfs_out_t spin_rhs(input lfs_in_t x);
    lfs_out_t y;
    logic signed [63:0] p[3], s[3], b[3], u[3], ub[3], sb[3], su[3];
    logic signed [63:0] bdu, udb, tp, lp;
    logic [63:0] sq, m, q;
    int j, k;
    p[0] = 64'(x.mom_x); p[1] = 64'(x.mom_y); p[2] = 64'(x.mom_z);
    s[0] = 64'(x.spin_x); s[1] = 64'(x.spin_y); s[2] = 64'(x.spin_z);
    b[0] = 64'(x.field_x); b[1] = 64'(x.field_y); b[2] = 64'(x.field_z);
    y = '0;
    sq = 0;
    for (int i = 0; i < 3; i++) sq += mag(p[i]) * mag(p[i]);
    if (sq == 0) begin
      y.zero_momentum = 1'b1;
      return y;
    end
    m = int_sqrt(sq);
    for (int i = 0; i < 3; i++) begin
      q = (mag(p[i]) << 16) / m;
      u[i] = p[i] < 0 ? -$signed(q) : $signed(q);
    end
    for (int i = 0; i < 3; i++) begin
      j = (i + 1) % 3;
      k = (i + 2) % 3;
      ub[i] = u[j] * b[k] - u[k] * b[j];
      sb[i] = prod_q16(s[j], b[k]) - prod_q16(s[k], b[j]);
      su[i] = s[j] * u[k] - s[k] * u[j];
    end
    bdu = b[0] * u[0] + b[1] * u[1] + b[2] * u[2];
    udb = 64'(scale_sat(bdu, 64'(k_long), 40));
    y.dir_x = 32'(u[0]); y.dir_y = 32'(u[1]); y.dir_z = 32'(u[2]);
    y.dmom_x = scale_sat(ub[0], 64'(k_lorentz), 40);
    y.dmom_y = scale_sat(ub[1], 64'(k_lorentz), 40);
    y.dmom_z = scale_sat(ub[2], 64'(k_lorentz), 40);
    tp = 64'(scale_sat(sb[0], 64'(k_trans), 24));
    lp = 64'(scale_sat(su[0], udb, 32));
    y.dspin_x = scale_sat(tp - lp, 64'(k_spin), 24);
    tp = 64'(scale_sat(sb[1], 64'(k_trans), 24));
    lp = 64'(scale_sat(su[1], udb, 32));
    y.dspin_y = scale_sat(tp - lp, 64'(k_spin), 24);
    tp = 64'(scale_sat(sb[2], 64'(k_trans), 24));
    lp = 64'(scale_sat(su[2], udb, 32));
    y.dspin_z = scale_sat(tp - lp, 64'(k_spin), 24);
    return y;
  endfunction

  task automatic report(input string what, input logic [31:0] got,
                        input logic [31:0] want);
    $display("error: %s got %h expected %h", what, got, want);
    errors++;
  endtask

  // Request driver.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      send_gap <= 0;
    end else if (!in_valid || !in_stall) begin
      if (send_gap > 0) begin
        in_valid <= 1'b0;
        send_gap <= send_gap - 1;
      end else if (request_queue.size() > 0) begin
        in_data <= request_queue[0];
        expected_rhs.push_back(spin_rhs(request_queue[0]));
        void'(request_queue.pop_front());
        in_valid <= 1'b1;
        if (!quiet && $urandom_range(0, 5) == 0) send_gap <= $urandom_range(1, 7);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result monitor with random stall bursts.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (rst) begin
      out_stall <= 1'b0;
      recv_gap <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_rhs.size() == 0) begin
          report("unexpected result", 32'd0, 32'd0);
        end else begin
          lfs_out_t w;
          w = expected_rhs.pop_front();
          if (out_data.dir_x !== w.dir_x) report("dir_x", out_data.dir_x, w.dir_x);
          if (out_data.dir_y !== w.dir_y) report("dir_y", out_data.dir_y, w.dir_y);
          if (out_data.dir_z !== w.dir_z) report("dir_z", out_data.dir_z, w.dir_z);
          if (out_data.dmom_x !== w.dmom_x) report("dmom_x", out_data.dmom_x, w.dmom_x);
          if (out_data.dmom_y !== w.dmom_y) report("dmom_y", out_data.dmom_y, w.dmom_y);
          if (out_data.dmom_z !== w.dmom_z) report("dmom_z", out_data.dmom_z, w.dmom_z);
          if (out_data.dspin_x !== w.dspin_x)
            report("dspin_x", out_data.dspin_x, w.dspin_x);
          if (out_data.dspin_y !== w.dspin_y)
            report("dspin_y", out_data.dspin_y, w.dspin_y);
          if (out_data.dspin_z !== w.dspin_z)
            report("dspin_z", out_data.dspin_z, w.dspin_z);
          if (out_data.zero_momentum !== w.zero_momentum)
            report("zero_momentum", 32'(out_data.zero_momentum), 32'(w.zero_momentum));
        end
      end
      if (recv_gap > 0) begin
        out_stall <= 1'b1;
        recv_gap <= recv_gap - 1;
      end else if (!quiet && $urandom_range(0, 6) == 0) begin
        out_stall <= 1'b1;
        recv_gap <= $urandom_range(0, 6);
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (cycles > CYCLE_LIMIT) begin
      $display("lorentz_force_spin_precession_rhs_core: mismatch");
      $finish;
    end
  end

  task automatic write_coef(input reg_idx_t idx, input logic [31:0] value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ADDR_W'(idx) << 2;
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_LORENTZ: k_lorentz = value;
      REG_SPIN: k_spin = value;
      REG_LONG: k_long = value;
      REG_TRANS: k_trans = value;
      default: ;
    endcase
  endtask

  task automatic drain;
    while (request_queue.size() > 0 || expected_rhs.size() > 0 || in_valid)
      @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  function automatic logic [31:0] rnd_word(input int mode);
    case (mode)
      0: return $urandom();
      1: return $signed(32'($urandom_range(0, 32'h3_ffff))) - 32'sh2_0000;
      2: return $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
      default: return $signed(32'($urandom_range(0, 32'h7ff))) - 32'sh400;
    endcase
  endfunction

  function automatic lfs_in_t rnd_request();
    lfs_in_t x;
    int mode;
    mode = $urandom_range(0, 3);
    x.mom_x = rnd_word(mode); x.mom_y = rnd_word(mode); x.mom_z = rnd_word(mode);
    x.spin_x = rnd_word($urandom_range(0, 3));
    x.spin_y = rnd_word($urandom_range(0, 3));
    x.spin_z = rnd_word($urandom_range(0, 3));
    x.field_x = rnd_word($urandom_range(0, 3));
    x.field_y = rnd_word($urandom_range(0, 3));
    x.field_z = rnd_word($urandom_range(0, 3));
    if ($urandom_range(0, 20) == 0) begin
      x.mom_x = 0; x.mom_y = 0; x.mom_z = 0;
    end
    return x;
  endfunction

  initial begin
    lfs_in_t x;
    logic [31:0] extremes[4];
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    out_stall = 1'b0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    k_lorentz = 0; k_spin = 0; k_long = 0; k_trans = 0;
    errors = 0;
    cycles = 0;
    quiet = 0;
    extremes = '{32'h7fff_ffff, 32'h8000_0000, 32'h0100_0000, 32'hff00_0000};
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Directed: zero momentum, single-axis, extreme components.
    write_coef(REG_LORENTZ, 32'h0100_0000);
    write_coef(REG_SPIN, 32'h0100_0000);
    write_coef(REG_LONG, 32'h0080_0000);
    write_coef(REG_TRANS, 32'hff00_0000);
    x = '0;
    request_queue.push_back(x);
    x.spin_x = 32'h0001_0000; x.field_z = 32'h0002_0000;
    request_queue.push_back(x);
    x.mom_x = 32'h0001_0000;
    request_queue.push_back(x);
    x.mom_x = 32'h8000_0000; x.mom_y = 32'h8000_0000; x.mom_z = 32'h8000_0000;
    request_queue.push_back(x);
    x = '{default: 32'h7fff_ffff};
    request_queue.push_back(x);
    x = '{default: 32'h8000_0000};
    request_queue.push_back(x);
    x.mom_x = 1; x.mom_y = 0; x.mom_z = 32'hffff_ffff;
    request_queue.push_back(x);
    x = '{default: 32'hffff_ffff};
    request_queue.push_back(x);
    for (int i = 0; i < 6; i++) request_queue.push_back(rnd_request());
    drain();

    for (int phase = 0; phase < 5; phase++) begin
      if (phase < 4) begin
        write_coef(REG_LORENTZ, $urandom_range(0, 1) ? extremes[phase] : $urandom());
        write_coef(REG_SPIN, extremes[(phase + 1) % 4]);
        write_coef(REG_LONG, $urandom_range(0, 1) ? extremes[(phase + 2) % 4] : $urandom());
        write_coef(REG_TRANS, extremes[(phase + 3) % 4]);
      end else begin
        quiet = 1;
        write_coef(REG_LORENTZ, $urandom());
        write_coef(REG_SPIN, $urandom());
        write_coef(REG_LONG, $urandom());
        write_coef(REG_TRANS, $urandom());
      end
      for (int i = 0; i < 100; i++) request_queue.push_back(rnd_request());
      drain();
    end

    if (errors == 0) begin
      $display("lorentz_force_spin_precession_rhs_core: match");
    end else begin
      $display("lorentz_force_spin_precession_rhs_core: mismatch");
    end
    $finish;
  end
endmodule
